@@ sv/pcmv_pkg.sv @@
// Package for the PCM clip player: sizes, operation and register codes,
// multiplier operand selects and the control struct of the shared multiplier.
// No dependencies.
package pcmv_pkg;

	localparam int MEM_DEPTH      = 4096;
	localparam int BLOCK_SAMPLES  = 64;
	localparam int SILENCE_BLOCKS = 8;

	localparam int ADDR_W = 12;
	localparam int LEN_W  = 13;
	localparam int VOL_W  = 7;
	localparam int SMP_W  = 8;
	localparam int SIL_W  = 4;
	localparam int CNT_W  = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
	localparam int CFG_W  = LEN_W;

	localparam logic [SMP_W-1:0] SILENCE_LEVEL = 8'h80;
	localparam logic [VOL_W-1:0] PERCENT       = 7'd100;
	localparam logic [VOL_W-1:0] VOL_RESET     = 7'd50;

	// x / 100 == (x * 5243) >> 19 for every x below 2^15
	localparam int MUL_A_W     = 15;
	localparam int MUL_B_W     = 13;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int RECIP_SHIFT = 19;
	localparam logic [MUL_B_W-1:0] RECIP_100 = 13'd5243;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_BLOCK = 2'd3;

	localparam logic [1:0] CFG_VOLUME = 2'd0;
	localparam logic [1:0] CFG_LOOP   = 2'd1;
	localparam logic [1:0] CFG_LENGTH = 2'd2;

	localparam logic [1:0] MUL_SAMPLE = 2'd0;
	localparam logic [1:0] MUL_MID    = 2'd1;
	localparam logic [1:0] MUL_RECIP  = 2'd2;

	typedef struct packed {
		logic       en;
		logic [1:0] src;
	} mul_ctrl_t;

endpackage

@@ sv/pcmv_if.sv @@
// Valid/ready channel interfaces for the PCM clip player.
// Depends on pcmv_pkg for field widths.
interface pcmv_in_if;
	import pcmv_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [ADDR_W-1:0] address;
	logic [SMP_W-1:0]  sample_value;

	modport source (output valid, op, address, sample_value, input ready);
	modport sink   (input valid, op, address, sample_value, output ready);
endinterface

interface pcmv_out_if;
	import pcmv_pkg::*;
	logic             valid;
	logic             ready;
	logic [SMP_W-1:0] sample;
	logic             last;
	logic             busy_res;

	modport source (output valid, sample, last, busy_res, input ready);
	modport sink   (input valid, sample, last, busy_res, output ready);
endinterface

@@ sv/pcmv_mul.sv @@
// Shared multiplier of the PCM clip player: one registered product per cycle
// while ctrl.en is set, operands picked by the sequencer. Depends on pcmv_pkg.
module pcmv_mul (
	input  logic                        clk,
	input  pcmv_pkg::mul_ctrl_t         ctrl,
	input  logic [pcmv_pkg::SMP_W-1:0]  smp,
	input  logic [pcmv_pkg::VOL_W-1:0]  vol,
	output logic [pcmv_pkg::PROD_W-1:0] prod
);
	import pcmv_pkg::*;

	logic [PROD_W-1:0] a;
	logic [PROD_W-1:0] b;
	logic [PROD_W-1:0] prod_q;

	always_comb begin
		case (ctrl.src)
			MUL_SAMPLE: begin
				a = PROD_W'(smp);
				b = PROD_W'(vol);
			end
			MUL_MID: begin
				a = PROD_W'(SILENCE_LEVEL);
				b = PROD_W'(vol);
			end
			MUL_RECIP: begin
				// reuse the last product as dividend
				a = PROD_W'(prod_q[MUL_A_W-1:0]);
				b = PROD_W'(RECIP_100);
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en)
			prod_q <= a * b;
	end

	assign prod = prod_q;
endmodule

@@ sv/pcm_clip_player_with_volume.sv @@
// Top level of the PCM clip player with volume: sequencer, sample memory,
// configuration registers and output register. Depends on pcmv_pkg,
// pcmv_if and pcmv_mul.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    op, address, sample_value
//  out_ch    out  valid/ready    sample, last, busy_res
//  cfg       in   cfg_we         cfg_index, cfg_data
//
// Write, start and stop are handled in ST_IDLE. A block request that plays
// runs bias setup (ST_BIAS_M, ST_BIAS_D), then per clip sample a memory read,
// two passes through the shared multiplier and an emit (ST_RD, ST_MUL,
// ST_DIV, ST_EMIT), and an emit alone per padding sample; a silence block
// only emits. The single multiplier serializes these steps. The output
// register holds a beat while out_ch stalls, and the sequencer waits on it.
// Reset clears control state; the sample memory is undefined until written.
module pcm_clip_player_with_volume (
	input  logic                        clk,
	input  logic                        arst_n,
	pcmv_in_if.sink                     in_ch,
	pcmv_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [pcmv_pkg::CFG_W-1:0]  cfg_data
);
	import pcmv_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_BIAS_M = 3'd1;
	localparam logic [2:0] ST_BIAS_D = 3'd2;
	localparam logic [2:0] ST_RD     = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	localparam logic [CNT_W-1:0] K_LAST = CNT_W'(BLOCK_SAMPLES - 1);

	logic [2:0]        state_q;
	logic [LEN_W-1:0]  play_idx_q;
	logic [SIL_W-1:0]  sil_left_q;
	logic [VOL_W-1:0]  vol_q;
	logic              loop_q;
	logic [LEN_W-1:0]  clip_len_q;
	logic [LEN_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  k_q;
	logic              silent_blk_q;
	logic              live_q;
	logic              busy_q;
	logic [SMP_W-1:0]  bias_q;
	logic [SMP_W-1:0]  rd_data_q;
	logic              out_valid_q;
	logic [SMP_W-1:0]  out_sample_q;
	logic              out_last_q;
	logic              out_busy_q;

	logic [SMP_W-1:0]  mem [MEM_DEPTH];

	mul_ctrl_t         mul_ctrl;
	logic [PROD_W-1:0] prod;
	logic [SMP_W-1:0]  quot;
	logic              in_fire;
	logic              emit_free;
	logic              playing;
	logic [LEN_W-1:0]  ptr_inc;
	logic [LEN_W-1:0]  ptr_nx;
	logic              live_nx;
	logic [LEN_W:0]    end_idx;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign emit_free = !out_valid_q || out_ch.ready;
	assign playing   = play_idx_q < clip_len_q;
	assign quot      = prod[RECIP_SHIFT +: SMP_W];
	assign end_idx   = (LEN_W+1)'(play_idx_q) + (LEN_W+1)'(BLOCK_SAMPLES);

	// advance the read pointer, wrapping at the clip end in loop mode
	assign ptr_inc = (loop_q && (ptr_q + LEN_W'(1) == clip_len_q)) ? '0 : ptr_q + LEN_W'(1);
	assign ptr_nx  = live_q ? ptr_inc : ptr_q;
	assign live_nx = !silent_blk_q && (loop_q || ptr_nx < clip_len_q);

	always_comb begin
		mul_ctrl.en  = 1'b0;
		mul_ctrl.src = MUL_SAMPLE;
		case (state_q)
			ST_BIAS_M: begin
				mul_ctrl.en  = 1'b1;
				mul_ctrl.src = MUL_MID;
			end
			ST_BIAS_D, ST_DIV: begin
				mul_ctrl.en  = 1'b1;
				mul_ctrl.src = MUL_RECIP;
			end
			ST_MUL: begin
				mul_ctrl.en  = 1'b1;
				mul_ctrl.src = MUL_SAMPLE;
			end
			default: begin
				mul_ctrl.en  = 1'b0;
				mul_ctrl.src = MUL_SAMPLE;
			end
		endcase
	end

	pcmv_mul u_mul (
		.clk  (clk),
		.ctrl (mul_ctrl),
		.smp  (rd_data_q),
		.vol  (vol_q),
		.prod (prod)
	);

	// sample memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_fire && in_ch.op == OP_WRITE && 32'(in_ch.address) < MEM_DEPTH)
			mem[in_ch.address] <= in_ch.sample_value;
		if (state_q == ST_RD)
			rd_data_q <= mem[ptr_q[ADDR_W-1:0]];
	end

	// configuration registers, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q      <= VOL_RESET;
			loop_q     <= 1'b0;
			clip_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VOLUME: vol_q <= (cfg_data[VOL_W-1:0] > PERCENT) ? PERCENT
					: cfg_data[VOL_W-1:0];
				CFG_LOOP:   loop_q <= cfg_data[0];
				CFG_LENGTH: clip_len_q <= (32'(cfg_data[LEN_W-1:0]) > MEM_DEPTH)
					? LEN_W'(MEM_DEPTH) : cfg_data[LEN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			play_idx_q   <= '0;
			sil_left_q   <= '0;
			out_valid_q  <= 1'b0;
			ptr_q        <= '0;
			k_q          <= '0;
			silent_blk_q <= 1'b0;
			live_q       <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			// load a new beat or hold the current one until it is taken
			out_valid_q <= (state_q == ST_EMIT && emit_free)
				|| (out_valid_q && !out_ch.ready);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_ch.op)
							OP_START: begin
								play_idx_q <= '0;
								sil_left_q <= SIL_W'(SILENCE_BLOCKS);
							end
							OP_STOP: play_idx_q <= clip_len_q;
							OP_BLOCK: begin
								k_q <= '0;
								if (playing) begin
									ptr_q        <= play_idx_q;
									silent_blk_q <= 1'b0;
									live_q       <= 1'b1;
									busy_q       <= loop_q
										|| (end_idx < (LEN_W+1)'(clip_len_q));
									state_q      <= ST_BIAS_M;
								end else if (sil_left_q != '0) begin
									sil_left_q   <= sil_left_q - SIL_W'(1);
									silent_blk_q <= 1'b1;
									live_q       <= 1'b0;
									busy_q       <= 1'b0;
									state_q      <= ST_EMIT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_BIAS_M: state_q <= ST_BIAS_D;
				ST_BIAS_D: state_q <= ST_RD;
				ST_RD:     state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_DIV;
				ST_DIV:    state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_free) begin
						if (k_q == K_LAST) begin
							if (!silent_blk_q)
								play_idx_q <= ptr_nx;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							ptr_q   <= ptr_nx;
							live_q  <= live_nx;
							state_q <= live_nx ? ST_RD : ST_EMIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bias = 128 - 128*volume/100, taken once per block
	always_ff @(posedge clk) begin
		if (state_q == ST_RD && k_q == '0)
			bias_q <= SILENCE_LEVEL - quot;
		if (state_q == ST_EMIT && emit_free) begin
			out_sample_q <= live_q ? quot + bias_q : SILENCE_LEVEL;
			out_last_q   <= k_q == K_LAST;
			out_busy_q   <= busy_q;
		end
	end

	assign in_ch.ready     = state_q == ST_IDLE;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.sample   = out_sample_q;
	assign out_ch.last     = out_last_q;
	assign out_ch.busy_res = out_busy_q;

`ifndef SYNTHESIS
	// never read past the clip
	a_read_in_clip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> ptr_q < clip_len_q)
		else $error("sample read beyond clip length");

	// silence beats carry the mid level
	a_silence_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_free && !live_q) |=> out_ch.sample == SILENCE_LEVEL)
		else $error("padding beat is not silence");

	// write, start and stop leave the input ready on the following cycle
	a_short_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_ch.op != OP_BLOCK) |=> in_ch.ready)
		else $error("short operation held the input");
`endif
endmodule
